// File: rtl/core/fasi_pkg.sv
// Shared types and constants for the four-axis step interleaver.
package fasi_pkg;

    localparam int AXES        = 4;
    localparam int LENGTH_BITS = 16;
    localparam int STEP_W      = 18;
    localparam int SPL_W       = 3;
    localparam int KIND_W      = 2;
    localparam int AXIS_W      = 2;
    localparam int DIV_CNT_W   = 5;

    localparam logic [SPL_W-1:0] SPL_RESET = 3'd2;
    localparam logic [SPL_W-1:0] SPL_MIN   = 3'd1;
    localparam logic [SPL_W-1:0] SPL_MAX   = 3'd4;

    typedef logic [KIND_W-1:0] kind_t;
    localparam kind_t KIND_MOVE = 2'd0;
    localparam kind_t KIND_TICK = 2'd1;
    localparam kind_t KIND_SET  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LMAX,
        ST_DIV_SETUP,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic              load_item;
        logic              exec;
        logic              load_lmax;
        logic              div_start;
        logic              div_write;
        logic              load_out;
        logic [AXIS_W-1:0] axis;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic move_go;
        logic count_nz;
        logic div_done;
    } stat_t;

endpackage

// File: rtl/core/fasi_div.sv
// Restoring divider, one quotient bit per cycle, for the step intervals.
module fasi_div import fasi_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [STEP_W-1:0] dividend,
    input  logic [STEP_W-1:0] divisor,
    output logic [STEP_W-1:0] quotient,
    output logic              done
);

    logic [STEP_W-1:0]    rem_reg, rem_next;
    logic [STEP_W-1:0]    quo_reg, quo_next;
    logic [STEP_W-1:0]    dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W:0]      shifted;
    logic                 ge;

    // one shift-subtract step
    assign shifted = {rem_reg, quo_reg[STEP_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? STEP_W'(shifted - {1'b0, dvs_reg}) : shifted[STEP_W-1:0];
            quo_next = {quo_reg[STEP_W-2:0], ge};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(STEP_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// File: rtl/core/fasi_dp.sv
// Datapath: axis state, move setup, tick stepping and the result register.
module fasi_dp import fasi_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [SPL_W-1:0]       cfg_data,
    input  cmd_t                   cmd,
    output stat_t                  stat,
    input  logic [KIND_W-1:0]      s_kind,
    input  logic [LENGTH_BITS-1:0] s_target_length_0,
    input  logic [LENGTH_BITS-1:0] s_target_length_1,
    input  logic [LENGTH_BITS-1:0] s_target_length_2,
    input  logic [LENGTH_BITS-1:0] s_target_length_3,
    output logic [AXES-1:0]        m_dir_mask,
    output logic [AXES-1:0]        m_step_mask,
    output logic                   m_busy_res,
    output logic                   m_done_res,
    output logic                   m_rejected
);

    logic [SPL_W-1:0]       spl_reg;
    logic [SPL_W-1:0]       eff_spl;
    kind_t                  kind_reg;
    logic [LENGTH_BITS-1:0] tgt_reg [AXES];
    logic [LENGTH_BITS-1:0] cur_reg [AXES], cur_next [AXES];
    logic [STEP_W-1:0]      rem_reg [AXES], rem_next [AXES];
    logic [STEP_W-1:0]      ivl_reg [AXES], ivl_next [AXES];
    logic [STEP_W-1:0]      cd_reg  [AXES], cd_next  [AXES];
    logic [STEP_W-1:0]      mv_cnt  [AXES];
    logic [LENGTH_BITS-1:0] diff    [AXES];
    logic [AXES-1:0]        dir_reg, dir_next;
    logic [AXES-1:0]        step_reg, step_next;
    logic                   moving_reg, moving_next;
    logic                   done_reg, done_next;
    logic                   rej_reg, rej_next;
    logic [STEP_W-1:0]      lmax_reg, lmax_next;
    logic [STEP_W-1:0]      div_q;
    logic                   div_done;
    logic [STEP_W-1:0]      ivl_val;
    logic [STEP_W-1:0]      cd_dec;
    logic                   any_cnt;
    logic                   any_left;

    // register clamp: 0 acts as 1, above 4 acts as 4
    always_comb begin
        if (spl_reg < SPL_MIN) begin
            eff_spl = SPL_MIN;
        end else if (spl_reg > SPL_MAX) begin
            eff_spl = SPL_MAX;
        end else begin
            eff_spl = spl_reg;
        end
    end

    // per-axis length difference and step count
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            if (tgt_reg[i] < cur_reg[i]) begin
                diff[i] = cur_reg[i] - tgt_reg[i];
            end else begin
                diff[i] = tgt_reg[i] - cur_reg[i];
            end
            mv_cnt[i] = STEP_W'(diff[i]) * STEP_W'(eff_spl);
        end
    end

    // largest step count of the move
    always_comb begin
        lmax_next = lmax_reg;
        if (cmd.load_lmax) begin
            lmax_next = '0;
            for (int i = 0; i < AXES; i++) begin
                if (rem_reg[i] > lmax_next) begin
                    lmax_next = rem_reg[i];
                end
            end
        end
    end

    fasi_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (lmax_reg),
        .divisor  (rem_reg[cmd.axis]),
        .quotient (div_q),
        .done     (div_done)
    );

    assign stat.move_go  = (kind_reg == KIND_MOVE) && !moving_reg;
    assign stat.count_nz = rem_reg[cmd.axis] != '0;
    assign stat.div_done = div_done;
    assign ivl_val       = stat.count_nz ? div_q : '0;

    // item execution and interval write-back
    always_comb begin
        cur_next    = cur_reg;
        rem_next    = rem_reg;
        ivl_next    = ivl_reg;
        cd_next     = cd_reg;
        dir_next    = dir_reg;
        moving_next = moving_reg;
        step_next   = step_reg;
        done_next   = done_reg;
        rej_next    = rej_reg;
        any_cnt     = 1'b0;
        any_left    = 1'b0;
        cd_dec      = '0;
        if (cmd.exec) begin
            step_next = '0;
            done_next = 1'b0;
            rej_next  = 1'b0;
            case (kind_reg)
                KIND_MOVE: begin
                    if (moving_reg) begin
                        rej_next = 1'b1;
                    end else begin
                        for (int i = 0; i < AXES; i++) begin
                            cur_next[i] = tgt_reg[i];
                            dir_next[i] = tgt_reg[i] < cur_reg[i];
                            rem_next[i] = mv_cnt[i];
                            if (mv_cnt[i] != '0) begin
                                any_cnt = 1'b1;
                            end
                        end
                        moving_next = any_cnt;
                    end
                end
                KIND_SET: begin
                    if (moving_reg) begin
                        rej_next = 1'b1;
                    end else begin
                        for (int i = 0; i < AXES; i++) begin
                            cur_next[i] = tgt_reg[i];
                        end
                    end
                end
                KIND_TICK: begin
                    if (moving_reg) begin
                        for (int i = 0; i < AXES; i++) begin
                            if (rem_reg[i] != '0) begin
                                cd_dec = (cd_reg[i] != '0) ? cd_reg[i] - STEP_W'(1) : cd_reg[i];
                                if (cd_dec == '0) begin
                                    step_next[i] = 1'b1;
                                    rem_next[i]  = rem_reg[i] - STEP_W'(1);
                                    cd_next[i]   = ivl_reg[i];
                                end else begin
                                    cd_next[i] = cd_dec;
                                end
                            end
                            if (rem_next[i] != '0) begin
                                any_left = 1'b1;
                            end
                        end
                        moving_next = any_left;
                        done_next   = !any_left;
                    end
                end
                default: ;
            endcase
        end
        if (cmd.div_write) begin
            ivl_next[cmd.axis] = ivl_val;
            cd_next[cmd.axis]  = ivl_val;
        end
    end

    // axis state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spl_reg    <= SPL_RESET;
            dir_reg    <= '0;
            moving_reg <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                cur_reg[i] <= '0;
                rem_reg[i] <= '0;
                ivl_reg[i] <= '0;
                cd_reg[i]  <= '0;
            end
        end else begin
            if (cfg_we) begin
                spl_reg <= cfg_data;
            end
            dir_reg    <= dir_next;
            moving_reg <= moving_next;
            cur_reg    <= cur_next;
            rem_reg    <= rem_next;
            ivl_reg    <= ivl_next;
            cd_reg     <= cd_next;
        end
    end

    // item capture, per-item flags and result payload
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg   <= s_kind;
            tgt_reg[0] <= s_target_length_0;
            tgt_reg[1] <= s_target_length_1;
            tgt_reg[2] <= s_target_length_2;
            tgt_reg[3] <= s_target_length_3;
        end
        lmax_reg <= lmax_next;
        step_reg <= step_next;
        done_reg <= done_next;
        rej_reg  <= rej_next;
        if (cmd.load_out) begin
            m_dir_mask  <= dir_reg;
            m_step_mask <= step_reg;
            m_busy_res  <= moving_reg;
            m_done_res  <= done_reg;
            m_rejected  <= rej_reg;
        end
    end

endmodule

// File: rtl/core/fasi_ctrl.sv
// Controller: sequences one item through execute, divide and result beat.
module fasi_ctrl import fasi_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t            state_reg, state_next;
    logic [AXIS_W-1:0] axis_reg, axis_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_free;
    logic              last_axis;

    assign out_free  = !m_valid_reg || m_ready;
    assign last_axis = axis_reg == AXIS_W'(AXES - 1);

    // next state
    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = stat.move_go ? ST_LMAX : ST_EMIT;
            end
            ST_LMAX: begin
                state_next = ST_DIV_SETUP;
                axis_next  = '0;
            end
            ST_DIV_SETUP: begin
                if (stat.count_nz) begin
                    state_next = ST_DIV_WAIT;
                end else if (last_axis) begin
                    state_next = ST_EMIT;
                end else begin
                    axis_next = axis_reg + AXIS_W'(1);
                end
            end
            ST_DIV_WAIT: begin
                if (stat.div_done) begin
                    if (last_axis) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_DIV_SETUP;
                        axis_next  = axis_reg + AXIS_W'(1);
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd           = '0;
        cmd.axis      = axis_reg;
        s_ready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            ST_EXEC:      cmd.exec      = 1'b1;
            ST_LMAX:      cmd.load_lmax = 1'b1;
            ST_DIV_SETUP: begin
                cmd.div_start = stat.count_nz;
                cmd.div_write = !stat.count_nz;
            end
            ST_DIV_WAIT:  cmd.div_write = stat.div_done;
            ST_EMIT:      cmd.load_out  = out_free;
            default: ;
        endcase
    end

    // result beat valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            axis_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            axis_reg    <= axis_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: rtl/core/four_axis_step_interleaver.sv
// Tick, set, rejected or unused item: executed, then the result beat is registered.
// Move: executed, then the largest step count is found and each axis gets its interval,
// moving axes from the shared 18-step restoring divider, still axes as zero.
// One item is in work at a time; the next is taken once the current result is registered.
// Reset (aresetn, synchronous, active low) clears lengths, counts, intervals, directions,
// the busy flag and the output valid, and sets steps_per_length to 2.
module four_axis_step_interleaver import fasi_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [SPL_W-1:0]       cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [KIND_W-1:0]      s_kind,
    input  logic [LENGTH_BITS-1:0] s_target_length_0,
    input  logic [LENGTH_BITS-1:0] s_target_length_1,
    input  logic [LENGTH_BITS-1:0] s_target_length_2,
    input  logic [LENGTH_BITS-1:0] s_target_length_3,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [AXES-1:0]        m_dir_mask,
    output logic [AXES-1:0]        m_step_mask,
    output logic                   m_busy_res,
    output logic                   m_done_res,
    output logic                   m_rejected
);

    cmd_t  cmd;
    stat_t stat;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    fasi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fasi_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_data          (cfg_data),
        .cmd               (cmd),
        .stat              (stat),
        .s_kind            (s_kind),
        .s_target_length_0 (s_target_length_0),
        .s_target_length_1 (s_target_length_1),
        .s_target_length_2 (s_target_length_2),
        .s_target_length_3 (s_target_length_3),
        .m_dir_mask        (m_dir_mask),
        .m_step_mask       (m_step_mask),
        .m_busy_res        (m_busy_res),
        .m_done_res        (m_done_res),
        .m_rejected        (m_rejected)
    );

endmodule

// File: rtl/core/fasi_checker.sv
// Port-level checks on the step interleaver, bound to the top level.
module fasi_checker import fasi_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [AXES-1:0]        m_dir_mask,
    input logic [AXES-1:0]        m_step_mask,
    input logic                   m_busy_res,
    input logic                   m_done_res,
    input logic                   m_rejected
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_dir_mask) && $stable(m_step_mask)
            && $stable(m_busy_res) && $stable(m_done_res) && $stable(m_rejected))
        else $error("result beat changed while stalled");

    // a finished move is no longer busy
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res)
        else $error("done reported while still busy");

    // a rejection only happens during a move and carries no step activity
    a_rej_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rejected |-> m_busy_res && m_step_mask == '0 && !m_done_res)
        else $error("rejection outside of a move");

    // step pulses only come from a move in progress or one just finished
    a_step_ctx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_step_mask != '0 |-> m_busy_res || m_done_res)
        else $error("step pulse without a move");

endmodule

bind four_axis_step_interleaver fasi_checker u_fasi_checker (.*);
